@@ sv/door_lock_password_controller_top_macros.svh @@
// ----------------------------------------------------------------------------
// Door lock controller assertion macros
// Shared property shorthands; all sample on i_clk, quiet while in reset.
// ----------------------------------------------------------------------------
`ifndef DOOR_LOCK_PASSWORD_CONTROLLER_TOP_MACROS_SVH
`define DOOR_LOCK_PASSWORD_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication
`define DLPC_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dlpc check failed");

// next-cycle implication
`define DLPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dlpc check failed");

`endif

@@ sv/dlpc_pkg.sv @@
// ----------------------------------------------------------------------------
// dlpc_pkg
// Types, codes and sizes shared by the door lock controller.
// ----------------------------------------------------------------------------
package dlpc_pkg;

    localparam int PASSWORD_CHARS = 5;
    localparam int PW_W           = 40;
    localparam int PW_BITS        = 8 * PASSWORD_CHARS;
    // compared bits: never more than the port carries
    localparam int PW_KEEP        = (PW_BITS < PW_W) ? PW_BITS : PW_W;

    // item modes
    localparam logic [1:0] MODE_ENTRY   = 2'd0;
    localparam logic [1:0] MODE_REQUEST = 2'd1;
    localparam logic [1:0] MODE_TICK    = 2'd2;

    // menu requests
    localparam logic REQ_OPEN   = 1'b0;
    localparam logic REQ_CHANGE = 1'b1;

    // report codes
    localparam logic [2:0] REP_PAIR_MATCH  = 3'd0;
    localparam logic [2:0] REP_PAIR_MISS   = 3'd1;
    localparam logic [2:0] REP_VERIFY_OK   = 3'd2;
    localparam logic [2:0] REP_VERIFY_FAIL = 3'd3;
    localparam logic [2:0] REP_DOOR        = 3'd4;
    localparam logic [2:0] REP_ALARM_OVER  = 3'd5;

    // reported modes
    localparam logic [1:0] RMODE_FIRST_BOOT = 2'd0;
    localparam logic [1:0] RMODE_RETRY      = 2'd1;
    localparam logic [1:0] RMODE_MENU       = 2'd2;
    localparam logic [1:0] RMODE_ALARM      = 2'd3;

    // motor drive
    localparam logic [1:0] MOTOR_STOP    = 2'd0;
    localparam logic [1:0] MOTOR_FORWARD = 2'd1;
    localparam logic [1:0] MOTOR_REVERSE = 2'd2;

    // config register indexes
    localparam logic [1:0] CFG_OPEN_SECONDS  = 2'd0;
    localparam logic [1:0] CFG_HOLD_SECONDS  = 2'd1;
    localparam logic [1:0] CFG_ALARM_SECONDS = 2'd2;
    localparam logic [1:0] CFG_MAX_TRIES     = 2'd3;

    typedef struct packed {
        logic [1:0]      mode;
        logic [PW_W-1:0] password;
        logic            request;
    } t_item;

    typedef struct packed {
        logic [2:0] report;
        logic [1:0] reported_mode;
        logic [1:0] motor_drive;
        logic       alarm_tone;
    } t_result;

    typedef struct packed {
        logic [7:0] open_seconds;
        logic [7:0] hold_seconds;
        logic [7:0] alarm_seconds;
        logic [2:0] max_tries;
    } t_cfg;

endpackage

@@ sv/dlpc_cfg.sv @@
// ----------------------------------------------------------------------------
// dlpc_cfg
// Configuration register file: timing limits and try count.
// ----------------------------------------------------------------------------
module dlpc_cfg
    import dlpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_we,
    input  logic [1:0] i_index,
    input  logic [7:0] i_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_index)
                CFG_OPEN_SECONDS:  n_cfg.open_seconds  = i_data;
                CFG_HOLD_SECONDS:  n_cfg.hold_seconds  = i_data;
                CFG_ALARM_SECONDS: n_cfg.alarm_seconds = i_data;
                CFG_MAX_TRIES:     n_cfg.max_tries     = i_data[2:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_seconds  <= 8'd15;
            r_cfg.hold_seconds  <= 8'd3;
            r_cfg.alarm_seconds <= 8'd60;
            r_cfg.max_tries     <= 3'd3;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/dlpc_core.sv @@
// ----------------------------------------------------------------------------
// dlpc_core
// Lock state machine: one item per enabled cycle, at most one result.
// ----------------------------------------------------------------------------
module dlpc_core
    import dlpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_go,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output logic    o_res_valid,
    output t_result o_res
);

    localparam logic [2:0] PH_FIRST_A = 3'd0;
    localparam logic [2:0] PH_FIRST_B = 3'd1;
    localparam logic [2:0] PH_MENU    = 3'd2;
    localparam logic [2:0] PH_VERIFY  = 3'd3;
    localparam logic [2:0] PH_FORWARD = 3'd4;
    localparam logic [2:0] PH_HOLD    = 3'd5;
    localparam logic [2:0] PH_REVERSE = 3'd6;
    localparam logic [2:0] PH_ALARM   = 3'd7;

    logic [2:0]         r_phase,  n_phase;
    logic [PW_KEEP-1:0] r_saved,  n_saved;
    logic [PW_KEEP-1:0] r_first,  n_first;
    logic [2:0]         r_tries,  n_tries;
    logic               r_action, n_action;
    logic [7:0]         r_ticks,  n_ticks;

    logic [PW_KEEP-1:0] pw;
    logic [7:0]         tick_limit;
    logic [8:0]         tick_next;
    logic               tick_done;
    logic [3:0]         used;

    assign pw   = i_item.password[PW_KEEP-1:0];
    assign used = {1'b0, r_tries} + 4'd1;

    always_comb begin
        case (r_phase)
            PH_HOLD:  tick_limit = i_cfg.hold_seconds;
            PH_ALARM: tick_limit = i_cfg.alarm_seconds;
            default:  tick_limit = i_cfg.open_seconds;
        endcase
    end

    // a limit of zero finishes on the first tick, same as one
    assign tick_next = {1'b0, r_ticks} + 9'd1;
    assign tick_done = tick_next >= {1'b0, tick_limit};

    always_comb begin
        n_phase     = r_phase;
        n_saved     = r_saved;
        n_first     = r_first;
        n_tries     = r_tries;
        n_action    = r_action;
        n_ticks     = r_ticks;
        o_res_valid = 1'b0;
        o_res       = '0;

        unique case (i_item.mode)
            MODE_ENTRY: begin
                unique case (r_phase)
                    PH_FIRST_A: begin
                        n_first = pw;
                        n_phase = PH_FIRST_B;
                    end
                    PH_FIRST_B: begin
                        o_res_valid = 1'b1;
                        if (pw == r_first) begin
                            n_saved             = pw;
                            n_phase             = PH_MENU;
                            o_res.report        = REP_PAIR_MATCH;
                            o_res.reported_mode = RMODE_MENU;
                        end else begin
                            n_phase             = PH_FIRST_A;
                            o_res.report        = REP_PAIR_MISS;
                            o_res.reported_mode = RMODE_FIRST_BOOT;
                        end
                    end
                    PH_VERIFY: begin
                        o_res_valid = 1'b1;
                        if (pw == r_saved) begin
                            o_res.report = REP_VERIFY_OK;
                            if (r_action == REQ_OPEN) begin
                                n_phase             = PH_FORWARD;
                                n_ticks             = '0;
                                o_res.reported_mode = RMODE_MENU;
                                o_res.motor_drive   = MOTOR_FORWARD;
                            end else begin
                                n_phase             = PH_FIRST_A;
                                o_res.reported_mode = RMODE_FIRST_BOOT;
                            end
                        end else begin
                            n_tries      = used[2:0];
                            o_res.report = REP_VERIFY_FAIL;
                            if (used >= {1'b0, i_cfg.max_tries}) begin
                                n_phase             = PH_ALARM;
                                n_ticks             = '0;
                                o_res.reported_mode = RMODE_ALARM;
                                o_res.alarm_tone    = 1'b1;
                            end else begin
                                o_res.reported_mode = RMODE_RETRY;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            MODE_REQUEST: begin
                if (r_phase == PH_MENU) begin
                    n_action = i_item.request;
                    n_tries  = '0;
                    n_phase  = PH_VERIFY;
                end
            end
            MODE_TICK: begin
                if (r_phase == PH_FORWARD || r_phase == PH_HOLD ||
                    r_phase == PH_REVERSE || r_phase == PH_ALARM) begin
                    n_ticks = tick_done ? 8'd0 : tick_next[7:0];
                    if (tick_done) begin
                        unique case (r_phase)
                            PH_FORWARD: begin
                                // zero hold: forward end doubles as hold end
                                if (i_cfg.hold_seconds == 8'd0) begin
                                    n_phase             = PH_REVERSE;
                                    o_res_valid         = 1'b1;
                                    o_res.report        = REP_DOOR;
                                    o_res.reported_mode = RMODE_MENU;
                                    o_res.motor_drive   = MOTOR_REVERSE;
                                end else begin
                                    n_phase = PH_HOLD;
                                end
                            end
                            PH_HOLD: begin
                                n_phase             = PH_REVERSE;
                                o_res_valid         = 1'b1;
                                o_res.report        = REP_DOOR;
                                o_res.reported_mode = RMODE_MENU;
                                o_res.motor_drive   = MOTOR_REVERSE;
                            end
                            PH_REVERSE: begin
                                n_phase             = PH_MENU;
                                o_res_valid         = 1'b1;
                                o_res.report        = REP_DOOR;
                                o_res.reported_mode = RMODE_MENU;
                            end
                            default: begin
                                n_phase             = PH_MENU;
                                o_res_valid         = 1'b1;
                                o_res.report        = REP_ALARM_OVER;
                                o_res.reported_mode = RMODE_MENU;
                            end
                        endcase
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FIRST_A;
            r_tries  <= '0;
            r_action <= 1'b0;
            r_ticks  <= '0;
        end else if (i_go) begin
            r_phase  <= n_phase;
            r_tries  <= n_tries;
            r_action <= n_action;
            r_ticks  <= n_ticks;
        end
    end

    // password stores: no reset, written before any read
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_saved <= n_saved;
            r_first <= n_first;
        end
    end

endmodule

@@ sv/door_lock_password_controller_top.sv @@
// ----------------------------------------------------------------------------
// door_lock_password_controller_top
// Password door lock controller with registered input and result words.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with i_mode, i_password, i_request. A word
// is taken at a clock edge with i_valid high and o_stall low.
// Result channel: o_valid / i_stall with o_report, o_reported_mode,
// o_motor_drive, o_alarm_tone. Items that cause no result produce no word.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index,
// i_cfg_data; write only while the block is idle.
// Result path: a taken item waits in the input register and steps into the
// result register, raising o_valid, once the result register is free.
// Throughput: one item per cycle while no result word is held; the state step
// is combinational logic between the input register and the result register.
// Stall: a held result word (o_valid with i_stall) holds every step, with or
// without a result; o_stall then rises while the input register is full.
// Reset: synchronous, active low; back to first boot waiting for the first
// entry, config registers at their defaults, both registers empty.
// ----------------------------------------------------------------------------
module door_lock_password_controller_top
    import dlpc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [1:0]      i_mode,
    input  logic [PW_W-1:0] i_password,
    input  logic            i_request,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [2:0]      o_report,
    output logic [1:0]      o_reported_mode,
    output logic [1:0]      o_motor_drive,
    output logic            o_alarm_tone,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [7:0]      i_cfg_data
);

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_v;
    t_result r_out;
    logic    r_out_v;
    t_result res;
    logic    res_valid;
    logic    step_go;
    logic    in_take;

    assign o_cfg_ready = 1'b1;

    dlpc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid & o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // step when the result slot is free or draining this cycle
    assign step_go = r_in_v && (!r_out_v || !i_stall);
    assign o_stall = r_in_v && !step_go;
    assign in_take = i_valid && !o_stall;

    dlpc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (step_go),
        .i_item      (r_in),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (in_take) begin
            r_in_v <= 1'b1;
        end else if (step_go) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.mode     <= i_mode;
            r_in.password <= i_password;
            r_in.request  <= i_request;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (step_go) begin
            r_out_v <= res_valid;
        end else if (!i_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_out_v;
    assign o_report        = r_out.report;
    assign o_reported_mode = r_out.reported_mode;
    assign o_motor_drive   = r_out.motor_drive;
    assign o_alarm_tone    = r_out.alarm_tone;

`include "door_lock_password_controller_top_macros.svh"

    `DLPC_ASSERT_IMPLY(a_no_step_over_held, r_out_v && i_stall, !step_go)
    `DLPC_ASSERT_IMPLY(a_full_take_drains, in_take && r_in_v, step_go)
    `DLPC_ASSERT_NEXT(a_item_kept, r_in_v && !step_go, r_in_v)
    `DLPC_ASSERT_IMPLY(a_buzzer_alarm_only, o_valid && o_alarm_tone,
        o_report == REP_VERIFY_FAIL && o_reported_mode == RMODE_ALARM)
    `DLPC_ASSERT_IMPLY(a_motor_door_only, o_valid && o_motor_drive != MOTOR_STOP,
        o_report == REP_VERIFY_OK || o_report == REP_DOOR)

endmodule
